@@ hw/rtl/idu_pkg.sv @@
// Package with register codes and fixed widths of the delta unfilter.
`default_nettype none

package idu_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int PIX_W      = 14;
	localparam int ROWS_W     = 16;
	localparam int BPP_W      = 3;
	localparam int COUNT_W    = 16;
	localparam int LEN_W      = 17;

	localparam logic [CFG_IDX_W-1:0] REG_LINE_PIXELS     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIXEL = 2'd2;

	localparam logic [7:0] MASK_ONES  = 8'hFF;
	localparam logic [7:0] MASK_ZEROS = 8'h00;

endpackage

`default_nettype wire

@@ hw/rtl/image_delta_unfilter.sv @@
// Top level of the delta row unfilter: unfold, predict and line store.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------------
//  in      | input     | in_valid / in_stall | packed_byte
//  out     | output    | out_valid/out_stall | pixel_byte, last_of_image, size_error
//  cfg     | input     | cfg_we              | cfg_index, cfg_data
//
// One byte is taken every cycle while the output is not stalled.
// Stage one holds the byte and line store read; the output register takes the sum.
// Reset clears counters and left history; the line store holds no reset value.
// A stall on the output holds the add stage and then the input.
`default_nettype none

module image_delta_unfilter
	import idu_pkg::*;
#(
	parameter int MAX_LINE_BYTES = 8192
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [7:0]            packed_byte,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [7:0]                 pixel_byte,
	output logic                       last_of_image,
	output logic                       size_error,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int ADDR_W = (MAX_LINE_BYTES > 1) ? $clog2(MAX_LINE_BYTES) : 1;

	logic [PIX_W-1:0]   line_pixels_q;
	logic [ROWS_W-1:0]  image_rows_q;
	logic [BPP_W-1:0]   bytes_per_pixel_q;

	logic [COUNT_W-1:0] col_q;
	logic [ROWS_W-1:0]  row_q;
	logic [1:0]         slot_q;
	logic [7:0]         hist_q [4];

	logic [7:0]         mem [MAX_LINE_BYTES];
	logic [7:0]         mem_rd_q;
	logic [7:0]         last_wr_q;

	logic               s1_v;
	logic [7:0]         u_s1;
	logic [ADDR_W-1:0]  addr_s1;
	logic               wr_s1;
	logic               row0_s1;
	logic               left_s1;
	logic [1:0]         slot_s1;
	logic               fwd_s1;
	logic               last_s1;
	logic               err_s1;

	logic               out_v_q;
	logic [7:0]         pixel_q;
	logic               last_q;
	logic               err_q;

	logic [PIX_W-1:0]   px_eff;
	logic [ROWS_W-1:0]  rows_eff;
	logic [BPP_W-1:0]   bpp_eff;
	logic [LEN_W-1:0]   line_len;
	logic               err;
	logic               col_end;
	logic               row_end;
	logic               accept;
	logic               s1_adv;
	logic [ADDR_W-1:0]  acc_addr;
	logic [7:0]         unfolded;
	logic [7:0]         pred;
	logic [7:0]         result;

	always_comb begin
		px_eff   = (line_pixels_q == '0) ? PIX_W'(1) : line_pixels_q;
		rows_eff = (image_rows_q == '0) ? ROWS_W'(1) : image_rows_q;
		case (bytes_per_pixel_q)
			3'd0:    bpp_eff = 3'd1;
			3'd1, 3'd2, 3'd3, 3'd4: bpp_eff = bytes_per_pixel_q;
			default: bpp_eff = 3'd4;
		endcase
		line_len = LEN_W'(px_eff) * LEN_W'(bpp_eff);
		err      = line_len > LEN_W'(MAX_LINE_BYTES);
		col_end  = (LEN_W'(col_q) + LEN_W'(1)) >= line_len;
		row_end  = (LEN_W'(row_q) + LEN_W'(1)) >= LEN_W'(rows_eff);
		acc_addr = col_q[ADDR_W-1:0];
		unfolded = (packed_byte >> 1) ^ (packed_byte[0] ? MASK_ONES : MASK_ZEROS);
	end

	assign s1_adv   = s1_v && (!out_v_q || !out_stall);
	assign in_stall = s1_v && !s1_adv;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		if (!wr_s1) begin
			pred = 8'd0;
		end else if (row0_s1) begin
			pred = left_s1 ? hist_q[slot_s1] : 8'd0;
		end else begin
			pred = fwd_s1 ? last_wr_q : mem_rd_q;
		end
		result = u_s1 + pred;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_pixels_q     <= PIX_W'(1);
			image_rows_q      <= ROWS_W'(1);
			bytes_per_pixel_q <= 3'd4;
			col_q             <= '0;
			row_q             <= '0;
			slot_q            <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LINE_PIXELS:     line_pixels_q     <= cfg_data[PIX_W-1:0];
				REG_IMAGE_ROWS:      image_rows_q      <= cfg_data[ROWS_W-1:0];
				REG_BYTES_PER_PIXEL: bytes_per_pixel_q <= cfg_data[BPP_W-1:0];
				default: ;
			endcase
			col_q  <= '0;
			row_q  <= '0;
			slot_q <= '0;
		end else if (accept) begin
			if (col_end) begin
				col_q  <= '0;
				slot_q <= '0;
				row_q  <= row_end ? '0 : row_q + ROWS_W'(1);
			end else begin
				col_q  <= col_q + COUNT_W'(1);
				slot_q <= ((BPP_W'(slot_q) + BPP_W'(1)) == bpp_eff) ? 2'd0 : slot_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && wr_s1) begin
			mem[addr_s1] <= result;
		end
		if (accept && !err) begin
			mem_rd_q <= mem[acc_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			u_s1      <= unfolded;
			addr_s1   <= acc_addr;
			wr_s1     <= !err;
			row0_s1   <= row_q == '0;
			left_s1   <= col_q >= COUNT_W'(bpp_eff);
			slot_s1   <= slot_q;
			fwd_s1    <= s1_v && wr_s1 && (addr_s1 == acc_addr);
			last_s1   <= row_end && col_end;
			err_s1    <= err;
			last_wr_q <= result;
		end
		if (s1_adv) begin
			pixel_q <= result;
			last_q  <= last_s1;
			err_q   <= err_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v    <= 1'b0;
			out_v_q <= 1'b0;
			for (int i = 0; i < 4; i++) begin
				hist_q[i] <= 8'd0;
			end
		end else begin
			if (accept) begin
				s1_v <= 1'b1;
			end else if (s1_adv) begin
				s1_v <= 1'b0;
			end
			if (s1_adv) begin
				out_v_q <= 1'b1;
			end else if (!out_stall) begin
				out_v_q <= 1'b0;
			end
			if (s1_adv && wr_s1) begin
				hist_q[slot_s1] <= result;
			end
		end
	end

	assign out_valid     = out_v_q;
	assign pixel_byte    = pixel_q;
	assign last_of_image = last_q;
	assign size_error    = err_q;

endmodule

`default_nettype wire

@@ hw/rtl/idu_checker.sv @@
// Port checker for the delta unfilter, bound to its top level.
`default_nettype none

module idu_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic [7:0] pixel_byte,
	input wire logic last_of_image,
	input wire logic size_error
);

	logic [1:0] pend_q;
	logic       in_xfer;
	logic       out_xfer;

	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(in_xfer) - 2'(out_xfer);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pixel_byte)
			&& $stable(last_of_image) && $stable(size_error))
		else $error("stalled result changed");

	a_out_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 2'd0)
		else $error("result shown without a pending transfer");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("more than two transfers in flight");

	a_empty_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled while the output is empty");

endmodule

bind image_delta_unfilter idu_checker u_idu_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.pixel_byte    (pixel_byte),
	.last_of_image (last_of_image),
	.size_error    (size_error)
);

`default_nettype wire

@@ bench/delta_unfilter_checker.sv @@
// Checker that predicts every rebuilt byte of the delta unfilter and compares it at the output.
module delta_unfilter_checker
	import idu_pkg::*;
#(
	parameter int MAX_LINE_BYTES = 8192
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic [7:0]            packed_byte,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic [7:0]            pixel_byte,
	input  logic                  last_of_image,
	input  logic                  size_error,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    failures,
	output int                    pending,
	output int                    checked,
	output int                    image_ends,
	output int                    overflows
);

	typedef struct packed {
		logic [7:0] pixel;
		logic       last;
		logic       err;
	} pixel_result_t;

	logic [PIX_W-1:0]  cfg_pixels;
	logic [ROWS_W-1:0] cfg_rows;
	logic [BPP_W-1:0]  cfg_bpp;
	logic [7:0]        above_row [MAX_LINE_BYTES];
	logic [7:0]        left_hist [4];
	int unsigned       col_pos;
	logic [ROWS_W-1:0] row_pos;
	pixel_result_t     expected_pixels [$];
	int                fail_total;
	int                seen_total;
	int                end_total;
	int                overflow_total;

	function automatic pixel_result_t rebuild_byte(input logic [7:0] code);
		int unsigned   width;
		int unsigned   rows;
		int unsigned   bpp;
		int unsigned   line_len;
		int unsigned   slot;
		logic [7:0]    delta;
		pixel_result_t r;
		width = (cfg_pixels == 0) ? 1 : cfg_pixels;
		rows = (cfg_rows == 0) ? 1 : cfg_rows;
		bpp = (cfg_bpp == 0) ? 1 : ((cfg_bpp > 4) ? 4 : cfg_bpp);
		line_len = width * bpp;
		delta = (code >> 1) ^ (code[0] ? MASK_ONES : MASK_ZEROS);
		r.pixel = delta;
		r.err = line_len > MAX_LINE_BYTES;
		if (!r.err && col_pos < line_len) begin
			slot = col_pos % bpp;
			if (row_pos == 0) begin
				if (col_pos >= bpp) begin
					r.pixel = delta + left_hist[slot];
				end
			end else begin
				r.pixel = delta + above_row[col_pos];
			end
			above_row[col_pos] = r.pixel;
			left_hist[slot] = r.pixel;
		end
		r.last = (row_pos + 1 >= rows) && (col_pos + 1 >= line_len);
		if (col_pos + 1 >= line_len) begin
			col_pos = 0;
			row_pos = (row_pos + 1 >= rows) ? '0 : row_pos + 1'b1;
		end else begin
			col_pos = col_pos + 1;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string field, input logic [7:0] want,
		input logic [7:0] got);
		fail_total++;
		if (fail_total <= 30) begin
			$display("%0t: %s expected %0h, got %0h", $time, field, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pixel_result_t want;
		if (!arst_n) begin
			cfg_pixels = 1;
			cfg_rows = 1;
			cfg_bpp = 4;
			for (int i = 0; i < 4; i++) begin
				left_hist[i] = '0;
			end
			col_pos = 0;
			row_pos = '0;
			expected_pixels.delete();
			fail_total = 0;
			seen_total = 0;
			end_total = 0;
			overflow_total = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_pixels.size() == 0) begin
					fail_total++;
					$display("%0t: output transfer %0h with no byte outstanding", $time,
						pixel_byte);
				end else begin
					want = expected_pixels.pop_front();
					seen_total++;
					if (pixel_byte !== want.pixel) begin
						report_mismatch("pixel_byte", want.pixel, pixel_byte);
					end
					if (last_of_image !== want.last) begin
						report_mismatch("last_of_image", 8'(want.last), 8'(last_of_image));
					end
					if (size_error !== want.err) begin
						report_mismatch("size_error", 8'(want.err), 8'(size_error));
					end
					if (want.last) begin
						end_total++;
					end
					if (want.err) begin
						overflow_total++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				expected_pixels.push_back(rebuild_byte(packed_byte));
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_LINE_PIXELS:     cfg_pixels = cfg_data[PIX_W-1:0];
					REG_IMAGE_ROWS:      cfg_rows = cfg_data[ROWS_W-1:0];
					REG_BYTES_PER_PIXEL: cfg_bpp = cfg_data[BPP_W-1:0];
					default: ;
				endcase
				col_pos = 0;
				row_pos = '0;
			end
		end
		failures <= fail_total;
		pending <= expected_pixels.size();
		checked <= seen_total;
		image_ends <= end_total;
		overflows <= overflow_total;
	end

endmodule

@@ bench/tb_top.sv @@
// Top of the delta unfilter bench: clock, reset, byte and register stimulus, and the verdict.
module tb_top;
	import idu_pkg::*;

	localparam int MAX_LINE = 8192;
	localparam int DIRECTED_ITEMS = 25;
	localparam int RANDOM_ITEMS = 1125;
	localparam int HOLD_CYCLES = 64;
	localparam int HOLD_SPACING = 350;
	localparam longint CYCLE_LIMIT = 500000;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [7:0]            packed_byte;
	logic                  out_valid;
	logic                  out_stall;
	logic [7:0]            pixel_byte;
	logic                  last_of_image;
	logic                  size_error;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int     failures;
	int     pending;
	int     checked;
	int     image_ends;
	int     overflows;
	int     items_sent;
	int     settings_used;
	int     holds;
	int     burst_left;
	int     gap_left;
	int     gap_max;
	longint cycle_count;

	image_delta_unfilter #(
		.MAX_LINE_BYTES(MAX_LINE)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.packed_byte(packed_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pixel_byte(pixel_byte),
		.last_of_image(last_of_image),
		.size_error(size_error),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	delta_unfilter_checker #(
		.MAX_LINE_BYTES(MAX_LINE)
	) pixel_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.packed_byte(packed_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pixel_byte(pixel_byte),
		.last_of_image(last_of_image),
		.size_error(size_error),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.failures(failures),
		.pending(pending),
		.checked(checked),
		.image_ends(image_ends),
		.overflows(overflows)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("end of test: mismatches");
		$finish;
	end

	// The receiver stalls in random segments and, once per spacing, holds off for a long
	// stretch while bytes are being offered so that the block backs up into its input.
	initial begin
		int level;
		int seg_left;
		int hold_left;
		int next_hold_at;
		logic stall_now;
		level = 0;
		seg_left = 0;
		hold_left = 0;
		next_hold_at = 150;
		holds = 0;
		forever begin
			if (hold_left > 0) begin
				hold_left--;
				stall_now = 1'b1;
			end else if (arst_n && in_valid && items_sent >= next_hold_at) begin
				hold_left = HOLD_CYCLES - 1;
				next_hold_at += HOLD_SPACING;
				holds++;
				stall_now = 1'b1;
			end else begin
				if (seg_left == 0) begin
					level = $urandom_range(0, 3);
					seg_left = $urandom_range(10, 60);
				end
				seg_left--;
				case (level)
					0: stall_now = 1'b0;
					1: stall_now = ($urandom_range(0, 3) == 0);
					2: stall_now = ($urandom_range(0, 1) == 0);
					default: stall_now = ($urandom_range(0, 9) < 8);
				endcase
			end
			out_stall <= stall_now;
			@(posedge clk);
		end
	end

	task automatic send_byte(input logic [7:0] value);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap_left = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
		end
		if (gap_left > 0) begin
			in_valid <= 1'b0;
			repeat (gap_left) @(posedge clk);
			gap_left = 0;
		end
		in_valid <= 1'b1;
		packed_byte <= value;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		burst_left--;
		items_sent++;
	endtask

	task automatic finish_phase();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic set_geometry(input logic [15:0] width_val, input logic [15:0] rows_val,
		input logic [15:0] bpp_val, input bit touch_spare);
		cfg_we <= 1'b1;
		cfg_index <= REG_LINE_PIXELS;
		cfg_data <= width_val;
		@(posedge clk);
		cfg_index <= REG_IMAGE_ROWS;
		cfg_data <= rows_val;
		@(posedge clk);
		cfg_index <= REG_BYTES_PER_PIXEL;
		cfg_data <= bpp_val;
		@(posedge clk);
		if (touch_spare) begin
			cfg_index <= REG_SPARE;
			cfg_data <= 16'($urandom_range(0, 65535));
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	initial begin
		logic [7:0] two_rows [14];
		logic [15:0] width_val;
		logic [15:0] rows_val;
		logic [15:0] bpp_val;
		int width_eff;
		int rows_eff;
		int bpp_eff;
		int line_len;
		int count;
		two_rows = '{8'hFE, 8'h01, 8'h80, 8'h7F, 8'hAA, 8'h55, 8'hFF,
			8'h00, 8'h02, 8'h03, 8'hFD, 8'hFC, 8'h81, 8'h7E};
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		packed_byte <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_LINE_PIXELS;
		cfg_data <= '0;
		items_sent = 0;
		settings_used = 0;
		burst_left = 0;
		gap_left = 0;
		gap_max = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Settings after reset: one pixel of four bytes, no prediction reaches across.
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h01);
		finish_phase();

		// Two rows of three two-byte pixels: left and above prediction, image end and wrap.
		set_geometry(16'd3, 16'd2, 16'd2, 1'b1);
		foreach (two_rows[i]) begin
			send_byte(two_rows[i]);
		end
		finish_phase();

		// Zero width, height and pixel size all act as one; the high data bits are dropped.
		set_geometry(16'hC000, 16'h0000, 16'h0000, 1'b0);
		send_byte(8'h7F);
		send_byte(8'h80);
		finish_phase();

		// One line just too long for the line store.
		set_geometry(16'd4097, 16'd1, 16'd2, 1'b0);
		send_byte(8'hFD);
		send_byte(8'h02);
		finish_phase();

		// Widest line that still fits, tallest image.
		set_geometry(16'd8192, 16'd65535, 16'd1, 1'b0);
		send_byte(8'h03);
		send_byte(8'hFC);
		finish_phase();

		// Pixel size above four acts as four.
		set_geometry(16'd2, 16'd2, 16'hFFFF, 1'b0);
		send_byte(8'h11);
		send_byte(8'hEE);
		finish_phase();

		while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
			case ($urandom_range(0, 3))
				0: gap_max = 0;
				1: gap_max = 1;
				2: gap_max = 3;
				default: gap_max = 6;
			endcase
			if ($urandom_range(0, 9) == 0) begin
				width_val = 16'($urandom_range(0, 65535));
				rows_val = 16'($urandom_range(0, 65535));
				bpp_val = 16'($urandom_range(0, 65535));
				count = $urandom_range(8, 40);
			end else begin
				width_val = 16'($urandom_range(0, 10)) | 16'($urandom_range(0, 3) << 14);
				rows_val = 16'($urandom_range(0, 4));
				bpp_val = 16'($urandom_range(0, 7)) | 16'($urandom_range(0, 8191) << 3);
				width_eff = (width_val[13:0] == 0) ? 1 : width_val[13:0];
				rows_eff = (rows_val == 0) ? 1 : rows_val;
				bpp_eff = (bpp_val[2:0] == 0) ? 1 : ((bpp_val[2:0] > 4) ? 4 : bpp_val[2:0]);
				line_len = width_eff * bpp_eff;
				count = line_len * rows_eff * $urandom_range(1, 2) + $urandom_range(0, line_len);
				if (count > 200) begin
					count = 200;
				end
			end
			if (count > DIRECTED_ITEMS + RANDOM_ITEMS - items_sent) begin
				count = DIRECTED_ITEMS + RANDOM_ITEMS - items_sent;
			end
			set_geometry(width_val, rows_val, bpp_val, $urandom_range(0, 4) == 0);
			for (int i = 0; i < count; i++) begin
				send_byte(8'($urandom_range(0, 255)));
			end
			finish_phase();
		end

		repeat (4) @(posedge clk);
		$display("Run summary: %0d bytes over %0d register settings, %0d results compared.",
			items_sent, settings_used, checked);
		$display("Seen %0d image ends, %0d overflowed-line bytes, %0d long receiver hold-offs.",
			image_ends, overflows, holds);
		if (failures == 0 && pending == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

@@ image_delta_unfilter.f @@
hw/rtl/idu_pkg.sv
hw/rtl/image_delta_unfilter.sv
hw/rtl/idu_checker.sv
bench/delta_unfilter_checker.sv
bench/tb_top.sv
